// ----- rtl/stp_pkg.sv -----
// Shared types and widths for the string to integer parser.
package stp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned BaseW  = 6;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 16;
  localparam int unsigned OutW   = ValueW + CountW;

  // One input character with its start marker
  typedef struct packed {
    logic             start_req;
    logic [CharW-1:0] character;
  } item_t;

  // One parse result, value in the low bits
  typedef struct packed {
    logic [CountW-1:0] consumed_count;
    logic [ValueW-1:0] value;
  } result_t;

endpackage

// ----- rtl/string_to_integer_parser.sv -----
// Streaming strtol-style parser: one character in, one integer out per string.
//
// Characters arrive on the s_axis channel, one per transfer: tdata[7:0] is
// the character and tuser[0] the start marker that opens a new conversion
// (and abandons any conversion in progress without a result). The radix is
// written on the cfg channel (0 selects automatic decimal, octal or hex)
// and is taken up when the next conversion starts; cfg_ready_o is always high.
// Leading blanks, a sign and a 0 or 0x prefix are accepted, then digits.
// The first character that is not a digit of the base ends the conversion
// and yields one m_axis transfer: tdata[63:0] is the signed value (wrapping
// modulo 2^64), tdata[79:64] the saturating count of consumed characters.
// Characters outside a conversion are taken and dropped.
// Throughput is one character per cycle while the receiver does not stall: the
// 64 by 6 bit multiply-add of the digit accumulator is combinational. A result
// passes from the input register, through the parser, to the result register.
// While the receiver stalls with a result held, the parser stops and the
// input register fills, after which s_axis_tready falls.
// Reset empties both registers, ends any conversion and clears the base to 0.
module string_to_integer_parser #(
  parameter longint unsigned COUNT_MAX = 65535
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration: number_base
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [stp_pkg::BaseW-1:0]  cfg_data_i,
  // Characters in
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [stp_pkg::CharW-1:0]  s_axis_tdata,  // [7:0] character
  input  logic                       s_axis_tuser,  // [0] start_req
  // Results out
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [stp_pkg::OutW-1:0]   m_axis_tdata   // [63:0] value, [79:64] consumed_count
);
  import stp_pkg::*;

  item_t   s_item, item;
  result_t res;
  logic    item_fire, res_valid, room;

  assign cfg_ready_o       = 1'b1;
  assign s_item.start_req  = s_axis_tuser;
  assign s_item.character  = s_axis_tdata;

  // Input register
  stp_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_item_i      (s_item),
    .drain_ok_i    (room),
    .item_fire_o   (item_fire),
    .item_o        (item)
  );

  // Parse state and update
  stp_parse_core #(
    .COUNT_MAX (COUNT_MAX)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .item_fire_i (item_fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  stp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- rtl/stp_in_stage.sv -----
// Input register stage: holds one accepted character until the parser takes it.
module stp_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  stp_pkg::item_t s_item_i,
  input  logic          drain_ok_i,
  output logic          item_fire_o,
  output stp_pkg::item_t item_o
);
  import stp_pkg::*;

  logic  full_q;
  item_t item_q;

  // Pass the held character on when the result side has room
  assign item_fire_o   = full_q & drain_ok_i;
  assign s_axis_tready = ~full_q | drain_ok_i;
  assign item_o        = item_q;

  // Track occupancy of the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (s_axis_tready) begin
      full_q <= s_axis_tvalid;
    end
  end

  // Capture the payload on each transfer
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= s_item_i;
    end
  end

endmodule

// ----- rtl/stp_parse_core.sv -----
// Parse state and per-character update: whitespace, sign, prefix and digits.
module stp_parse_core #(
  parameter longint unsigned COUNT_MAX = 65535
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [stp_pkg::BaseW-1:0] cfg_data_i,
  input  logic                      item_fire_i,
  input  stp_pkg::item_t            item_i,
  output logic                      res_valid_o,
  output stp_pkg::result_t          res_o
);
  import stp_pkg::*;

  localparam int unsigned CntW = $clog2(COUNT_MAX + 64'd1);
  localparam int unsigned ExtW = (CntW > CountW) ? CntW : CountW;
  localparam logic [CntW-1:0] CntMax = CntW'(COUNT_MAX);

  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharLowX  = 8'h78;
  localparam logic [CharW-1:0] CharLowZ  = 8'h7A;
  localparam logic [CharW-1:0] CharUpA   = 8'h41;
  localparam logic [CharW-1:0] CharUpZ   = 8'h5A;

  localparam logic [BaseW-1:0] BaseAuto = 6'd0;
  localparam logic [BaseW-1:0] BaseOct  = 6'd8;
  localparam logic [BaseW-1:0] BaseDec  = 6'd10;
  localparam logic [BaseW-1:0] BaseHex  = 6'd16;
  localparam logic [BaseW-1:0] LetterOff = 6'd10;

  typedef enum logic [2:0] {
    PhDone,
    PhSpace,
    PhPrefix,
    PhZero,
    PhDigits
  } phase_e;

  phase_e              phase_q, phase_d, phase_cur;
  logic [ValueW-1:0]   acc_q, acc_d, acc_cur;
  logic [CntW-1:0]     cnt_q, cnt_d, cnt_cur;
  logic                neg_q, neg_d, neg_cur;
  logic [BaseW-1:0]    base_q, base_d, base_cur;
  logic [BaseW-1:0]    number_base_q;
  logic [CharW-1:0]    chr;
  logic [BaseW-1:0]    dig;
  logic                dig_ok;
  logic                to_prefix, to_digit, bump, emit;
  logic [ExtW-1:0]     cnt_ext;

  assign chr = item_i.character;

  // Decode an alphanumeric character to its digit value
  always_comb begin
    dig    = '0;
    dig_ok = 1'b0;
    if (chr >= CharZero && chr <= CharNine) begin
      dig    = BaseW'(chr - CharZero);
      dig_ok = 1'b1;
    end else if (chr >= CharLowA && chr <= CharLowZ) begin
      dig    = BaseW'(chr - CharLowA) + LetterOff;
      dig_ok = 1'b1;
    end else if (chr >= CharUpA && chr <= CharUpZ) begin
      dig    = BaseW'(chr - CharUpA) + LetterOff;
      dig_ok = 1'b1;
    end
  end

  // Work out the next parse state for the current character
  always_comb begin
    phase_cur = item_i.start_req ? PhSpace       : phase_q;
    acc_cur   = item_i.start_req ? '0            : acc_q;
    cnt_cur   = item_i.start_req ? '0            : cnt_q;
    neg_cur   = item_i.start_req ? 1'b0          : neg_q;
    base_cur  = item_i.start_req ? number_base_q : base_q;

    phase_d   = phase_cur;
    acc_d     = acc_cur;
    cnt_d     = cnt_cur;
    neg_d     = neg_cur;
    base_d    = base_cur;
    to_prefix = 1'b0;
    to_digit  = 1'b0;
    bump      = 1'b0;
    emit      = 1'b0;

    unique case (phase_cur)
      PhDone: begin
      end
      PhSpace: begin
        if (chr == CharSpace || chr == CharTab) begin
          bump = 1'b1;
        end else if (chr == CharPlus || chr == CharMinus) begin
          neg_d   = neg_cur | (chr == CharMinus);
          bump    = 1'b1;
          phase_d = PhPrefix;
        end else begin
          to_prefix = 1'b1;
        end
      end
      PhPrefix: begin
        to_prefix = 1'b1;
      end
      PhZero: begin
        if (chr == CharLowX) begin
          bump    = 1'b1;
          base_d  = BaseHex;
          phase_d = PhDigits;
        end else begin
          if (base_cur == BaseAuto) begin
            base_d = BaseOct;
          end
          to_digit = 1'b1;
        end
      end
      PhDigits: begin
        to_digit = 1'b1;
      end
      default: begin
      end
    endcase

    // Optional leading zero of an octal or hex prefix
    if (to_prefix) begin
      if ((base_cur == BaseAuto || base_cur == BaseHex) && chr == CharZero) begin
        bump    = 1'b1;
        phase_d = PhZero;
      end else begin
        if (base_cur == BaseAuto) begin
          base_d = BaseDec;
        end
        to_digit = 1'b1;
      end
    end

    // Accumulate a digit or end the conversion
    if (to_digit) begin
      if (dig_ok && dig < base_d) begin
        acc_d   = acc_cur * ValueW'(base_d) + ValueW'(dig);
        bump    = 1'b1;
        phase_d = PhDigits;
      end else begin
        phase_d = PhDone;
        emit    = 1'b1;
      end
    end

    // Saturating character count
    if (bump && cnt_cur < CntMax) begin
      cnt_d = cnt_cur + CntW'(1);
    end
  end

  // Build the result from the state before the terminating character
  assign cnt_ext               = ExtW'(cnt_cur);
  assign res_valid_o           = item_fire_i & emit;
  assign res_o.value           = neg_cur ? (ValueW'(0) - acc_cur) : acc_cur;
  assign res_o.consumed_count  = (cnt_ext > ExtW'({CountW{1'b1}})) ? {CountW{1'b1}}
                                                                    : cnt_ext[CountW-1:0];

  // Hold the base register and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= '0;
      phase_q       <= PhDone;
      acc_q         <= '0;
      cnt_q         <= '0;
      neg_q         <= 1'b0;
      base_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        number_base_q <= cfg_data_i;
      end
      if (item_fire_i) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        neg_q   <= neg_d;
        base_q  <= base_d;
      end
    end
  end

  // A result always closes the conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> phase_q == PhDone)
    else $error("parser still active after giving a result");

  // Count never runs past its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("character count beyond limit");

  // Digits are only taken once a concrete base is chosen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDigits |-> base_q != BaseAuto)
    else $error("digit phase entered with automatic base");

endmodule

// ----- rtl/stp_out_stage.sv -----
// Result register: holds one parse result until the receiver takes it.
module stp_out_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     res_valid_i,
  input  stp_pkg::result_t         res_i,
  output logic                     room_o,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [stp_pkg::OutW-1:0] m_axis_tdata
);
  import stp_pkg::*;

  logic    valid_q;
  result_t res_q;

  // Room for a new result once the held one leaves
  assign room_o        = ~valid_q | m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q;

  // Track the held result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (room_o) begin
      valid_q <= res_valid_i;
    end
  end

  // Load the payload on a new result
  always_ff @(posedge clk_i) begin
    if (room_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule
